// ----- hdl/a64ic_pkg.sv -----
// Package for the A64 instruction classifier: record kinds, encoding masks
// and the decoded record type. No dependencies.
package a64ic_pkg;

  // Record kinds
  typedef enum logic [3:0] {
    KIND_SVC     = 4'd0,
    KIND_BRREG   = 4'd1,
    KIND_B       = 4'd2,
    KIND_BCOND   = 4'd3,
    KIND_CBZ     = 4'd4,
    KIND_TBZ     = 4'd5,
    KIND_ADR     = 4'd6,
    KIND_ADRP    = 4'd7,
    KIND_MOVWIDE = 4'd8,
    KIND_NOP     = 4'd9,
    KIND_BRK     = 4'd10,
    KIND_GENERIC = 4'd11,
    KIND_FAULT   = 4'd12
  } kind_e;

  // Encoding masks and match values
  localparam logic [31:0] SVC_MASK   = 32'hffe0_001f;
  localparam logic [31:0] SVC_MATCH  = 32'hd400_0001;
  localparam logic [31:0] BR_MASK    = 32'hffff_fc1f;
  localparam logic [31:0] BR_MATCH   = 32'hd61f_0000;
  localparam logic [31:0] B_MASK     = 32'h7c00_0000;
  localparam logic [31:0] B_MATCH    = 32'h1400_0000;
  localparam logic [31:0] BCOND_MASK = 32'hff00_0010;
  localparam logic [31:0] BCOND_MATCH = 32'h5400_0000;
  localparam logic [31:0] CB_MASK    = 32'h7e00_0000;
  localparam logic [31:0] CBZ_MATCH  = 32'h3400_0000;
  localparam logic [31:0] TBZ_MATCH  = 32'h3600_0000;
  localparam logic [31:0] ADR_MASK   = 32'h1f00_0000;
  localparam logic [31:0] ADR_MATCH  = 32'h1000_0000;
  localparam logic [31:0] MOVW_MASK  = 32'h1f80_0000;
  localparam logic [31:0] MOVW_MATCH = 32'h1280_0000;
  localparam logic [31:0] NOP_WORD   = 32'hd503_201f;
  localparam logic [31:0] BRK_MASK   = 32'hffe0_0000;
  localparam logic [31:0] BRK_MATCH  = 32'hd420_0000;

  // Beat widths
  localparam int unsigned InDataW  = 160;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 184;
  localparam int unsigned OutUserW = 4;

  // Input item as held in the input register
  typedef struct packed {
    logic [31:0] insn_word;
    logic [63:0] insn_addr;
    logic        fetch_fault;
    logic [63:0] fault_data_addr;
    logic        generic_ends;
  } a64ic_item_t;

  // Decoded record
  typedef struct packed {
    kind_e              kind;
    logic [4:0]         reg_num;
    logic signed [27:0] offset;
    logic               flag_a;
    logic               flag_b;
    logic [5:0]         bit_num;
    logic [3:0]         cond_code;
    logic [1:0]         move_opc;
    logic [1:0]         shift_hw;
    logic               ends_block;
    logic [63:0]        wide_word;
    logic [63:0]        record_addr;
  } a64ic_rec_t;

endpackage

// ----- hdl/a64ic_decode.sv -----
// Combinational A64 word decoder: matches one held item against the class
// encodings and builds its record. Depends on a64ic_pkg.
module a64ic_decode import a64ic_pkg::*; (
  input  a64ic_item_t item_i,
  output a64ic_rec_t  rec_o
);

  logic [31:0] w;
  assign w = item_i.insn_word;

  // Match classes in priority order; unused fields stay zero
  always_comb begin
    rec_o             = '0;
    rec_o.kind        = KIND_GENERIC;
    rec_o.record_addr = item_i.insn_addr;
    priority if (item_i.fetch_fault) begin
      rec_o.kind       = KIND_FAULT;
      rec_o.ends_block = 1'b1;
      rec_o.wide_word  = item_i.fault_data_addr;
    end else if ((w & SVC_MASK) == SVC_MATCH) begin
      rec_o.kind       = KIND_SVC;
      rec_o.ends_block = 1'b1;
    end else if ((w & BR_MASK) == BR_MATCH) begin
      rec_o.kind       = KIND_BRREG;
      rec_o.reg_num    = w[9:5];
      rec_o.ends_block = 1'b1;
    end else if ((w & B_MASK) == B_MATCH) begin
      rec_o.kind       = KIND_B;
      rec_o.offset     = {w[25:0], 2'b00};
      rec_o.flag_a     = w[31];
      rec_o.ends_block = 1'b1;
    end else if ((w & BCOND_MASK) == BCOND_MATCH) begin
      rec_o.kind       = KIND_BCOND;
      rec_o.cond_code  = w[3:0];
      rec_o.offset     = {{7{w[23]}}, w[23:5], 2'b00};
      rec_o.ends_block = 1'b1;
    end else if ((w & CB_MASK) == CBZ_MATCH) begin
      rec_o.kind       = KIND_CBZ;
      rec_o.flag_a     = w[31];
      rec_o.flag_b     = w[24];
      rec_o.reg_num    = w[4:0];
      rec_o.offset     = {{7{w[23]}}, w[23:5], 2'b00};
      rec_o.ends_block = 1'b1;
    end else if ((w & CB_MASK) == TBZ_MATCH) begin
      rec_o.kind       = KIND_TBZ;
      rec_o.flag_b     = w[24];
      rec_o.reg_num    = w[4:0];
      rec_o.bit_num    = {w[31], w[23:19]};
      rec_o.offset     = {{12{w[18]}}, w[18:5], 2'b00};
      rec_o.ends_block = 1'b1;
    end else if ((w & ADR_MASK) == ADR_MATCH) begin
      // immlo in the low bits, immhi above; pages are not scaled
      rec_o.kind    = w[31] ? KIND_ADRP : KIND_ADR;
      rec_o.reg_num = w[4:0];
      rec_o.offset  = {{7{w[23]}}, w[23:5], w[30:29]};
    end else if ((w & MOVW_MASK) == MOVW_MATCH) begin
      rec_o.kind     = KIND_MOVWIDE;
      rec_o.flag_a   = w[31];
      rec_o.move_opc = w[30:29];
      rec_o.shift_hw = w[22:21];
      rec_o.reg_num  = w[4:0];
      rec_o.offset   = {12'd0, w[20:5]};
    end else if (w == NOP_WORD) begin
      rec_o.kind = KIND_NOP;
    end else if ((w & BRK_MASK) == BRK_MATCH) begin
      rec_o.kind       = KIND_BRK;
      rec_o.ends_block = 1'b1;
    end else begin
      rec_o.kind       = KIND_GENERIC;
      rec_o.wide_word  = {32'd0, w};
      rec_o.ends_block = item_i.generic_ends;
    end
  end

endmodule

// ----- hdl/a64_instruction_classifier.sv -----
// Top level of the A64 instruction classifier: input register, decoder and
// result register on stream channels. Depends on a64ic_pkg, a64ic_decode.
// Path: an accepted input beat is held in the input register and decoded, and
// its record is held in the result register before it is offered.
// Throughput: one word per cycle while the output does not stall; the two register stages
// advance whenever the stage ahead is empty or is drained in the same cycle.
// Reset: both stage valid flags clear; payload registers are not reset.
module a64_instruction_classifier import a64ic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] insn_word, [95:32] insn_addr, [159:96] fault_data_addr
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] fetch_fault, [1] generic_ends
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [4:0] reg_num, [32:5] offset, [33] flag_a, [34] flag_b, [40:35] bit_num,
  // [44:41] cond_code, [46:45] move_opc, [48:47] shift_hw,
  // [112:49] wide_word, [176:113] record_addr, [183:177] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [3:0] kind
  output logic [OutUserW-1:0] m_axis_tuser,
  // ends_block
  output logic                m_axis_tlast
);

  logic        in_valid_q, in_valid_d;
  logic        out_valid_q, out_valid_d;
  logic        out_adv, in_acc;
  a64ic_item_t item_q, item_in;
  a64ic_rec_t  rec_q, rec_d;

  // Stage handshakes
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Unpack the input beat
  assign item_in.insn_word       = s_axis_tdata[31:0];
  assign item_in.insn_addr       = s_axis_tdata[95:32];
  assign item_in.fault_data_addr = s_axis_tdata[159:96];
  assign item_in.fetch_fault     = s_axis_tuser[0];
  assign item_in.generic_ends    = s_axis_tuser[1];

  // Advance stage valid flags
  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = in_valid_q;
      in_valid_d  = 1'b0;
    end
    if (in_acc) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the input beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_in;
    end
  end

  a64ic_decode u_decode (
    .item_i (item_q),
    .rec_o  (rec_d)
  );

  // Hold the result beat
  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      rec_q <= rec_d;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = rec_q.kind;
  assign m_axis_tlast  = rec_q.ends_block;
  assign m_axis_tdata  = {7'd0, rec_q.record_addr, rec_q.wide_word, rec_q.shift_hw,
                          rec_q.move_opc, rec_q.cond_code, rec_q.bit_num, rec_q.flag_b,
                          rec_q.flag_a, rec_q.offset, rec_q.reg_num};

  // A fault record always closes the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rec_q.kind == KIND_FAULT) |-> m_axis_tlast)
    else $error("fault record without end of block");

  // Address forming, moves and NOP never close the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (rec_q.kind == KIND_ADR || rec_q.kind == KIND_ADRP ||
                       rec_q.kind == KIND_MOVWIDE || rec_q.kind == KIND_NOP))
    |-> !m_axis_tlast)
    else $error("non-branch record marked end of block");

  // A held item moves into the result stage when that stage frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_adv) |=> out_valid_q)
    else $error("held item lost on advance");

  // A full input stage behind a stalled result stage takes no beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_adv) |-> !s_axis_tready)
    else $error("input accepted while pipeline is full");

endmodule
